/* hw/rtl/owrs_pkg.sv */
// ----------------------------------------------------------------------------
// owrs_pkg
// Shared types and constants of the 1-Wire search ROM engine.
// ----------------------------------------------------------------------------
package owrs_pkg;

   // rom code and search geometry
   localparam int ROM_W        = 64;
   localparam int ROM_BITS     = 64;
   localparam int ROM_IDX_W    = $clog2(ROM_W);
   localparam int POS_W        = 7;
   localparam int FAM_W        = 4;
   localparam int FAMILY_LIMIT = 9;
   localparam int CMD_W        = 8;
   localparam int ACT_W        = 2;
   localparam int KIND_W       = 2;

   // result buffer geometry
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // request action codes
   typedef enum logic [ACT_W-1:0] {
      ACT_START = 2'd0,
      ACT_BIT   = 2'd1,
      ACT_RESET = 2'd2
   } action_type;

   // result kind codes
   typedef enum logic [KIND_W-1:0] {
      KIND_CMD   = 2'd0,
      KIND_DIR   = 2'd1,
      KIND_FOUND = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   // request beat
   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic             presence;
      logic [CMD_W-1:0] search_command;
      logic             id_bit;
      logic             complement_bit;
   } req_type;

   // result beat
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CMD_W-1:0]  bus_value;
      logic [ROM_W-1:0]  rom_code;
      logic [POS_W-1:0]  discrepancy;
      logic [FAM_W-1:0]  family_discrepancy;
      logic              last;
   } rsp_type;

   // up to two results pushed per processed request
   typedef struct packed {
      logic    push0;
      logic    push1;
      rsp_type res0;
      rsp_type res1;
   } push_type;

endpackage

/* hw/rtl/owrs_if.sv */
// ----------------------------------------------------------------------------
// owrs_if
// Valid/ready channels for search requests and search results.
// ----------------------------------------------------------------------------
interface owrs_req_if;
   import owrs_pkg::*;

   logic             valid;
   logic             ready;
   logic [ACT_W-1:0] action;
   logic             presence;
   logic [CMD_W-1:0] search_command;
   logic             id_bit;
   logic             complement_bit;

   modport source (
      output valid, action, presence, search_command, id_bit, complement_bit,
      input  ready
   );
   modport sink (
      input  valid, action, presence, search_command, id_bit, complement_bit,
      output ready
   );
endinterface

interface owrs_rsp_if;
   import owrs_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [CMD_W-1:0]  bus_value;
   logic [ROM_W-1:0]  rom_code;
   logic [POS_W-1:0]  discrepancy;
   logic [FAM_W-1:0]  family_discrepancy;
   logic              last;

   modport source (
      output valid, kind, bus_value, rom_code, discrepancy, family_discrepancy, last,
      input  ready
   );
   modport sink (
      input  valid, kind, bus_value, rom_code, discrepancy, family_discrepancy, last,
      output ready
   );
endinterface

/* hw/rtl/owrs_core.sv */
// ----------------------------------------------------------------------------
// owrs_core
// Request register, search state and the one-pass search step.
// ----------------------------------------------------------------------------
module owrs_core
   import owrs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  req_type  req_beat,
   output logic     req_ready,
   input  logic     room,
   output push_type push
);

   // request register
   logic    in_valid_ff, in_valid_in;
   req_type in_ff, in_in;
   logic    step_en;

   // search state
   logic [ROM_W-1:0] rom_ff, rom_in;
   logic [POS_W-1:0] last_disc_ff, last_disc_in;
   logic             last_dev_ff, last_dev_in;
   logic [FAM_W-1:0] fam_ff, fam_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] turn_pos_ff, turn_pos_in;
   logic             searching_ff, searching_in;

   // step helpers
   logic [POS_W-1:0]     pos_m1;
   logic [ROM_IDX_W-1:0] bit_idx;
   logic                 dir;
   logic                 a_bit, b_bit;

   function automatic rsp_type make_rsp(kind_type k, logic [CMD_W-1:0] v,
                                        logic [ROM_W-1:0] rom, logic [POS_W-1:0] disc,
                                        logic [FAM_W-1:0] fam, logic fin);
      rsp_type r;
      r.kind               = k;
      r.bus_value          = v;
      r.rom_code           = rom;
      r.discrepancy        = disc;
      r.family_discrepancy = fam;
      r.last               = fin;
      return r;
   endfunction

   // request handshake: hold one beat, release it when results fit
   assign step_en   = in_valid_ff && room;
   assign req_ready = !in_valid_ff || room;

   always_comb begin
      in_in       = in_ff;
      in_valid_in = in_valid_ff;
      if (step_en) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_in       = req_beat;
         in_valid_in = 1'b1;
      end
   end

   // bit position and selected rom bit
   assign pos_m1  = pos_ff - POS_W'(1);
   assign bit_idx = pos_m1[ROM_IDX_W-1:0];
   assign a_bit   = in_ff.id_bit;
   assign b_bit   = in_ff.complement_bit;

   // search step
   always_comb begin
      rom_in       = rom_ff;
      last_disc_in = last_disc_ff;
      last_dev_in  = last_dev_ff;
      fam_in       = fam_ff;
      pos_in       = pos_ff;
      turn_pos_in  = turn_pos_ff;
      searching_in = searching_ff;
      dir          = 1'b0;
      push         = '0;
      if (step_en) begin
         case (action_type'(in_ff.action))
            ACT_START: begin
               pos_in       = POS_W'(1);
               turn_pos_in  = '0;
               if (last_dev_ff || !in_ff.presence) begin
                  searching_in = 1'b0;
                  last_disc_in = '0;
                  last_dev_in  = 1'b0;
                  fam_in       = '0;
                  push.push0   = 1'b1;
                  push.res0    = make_rsp(KIND_NONE, '0, rom_ff, '0, '0, 1'b1);
               end else begin
                  searching_in = 1'b1;
                  push.push0   = 1'b1;
                  push.res0    = make_rsp(KIND_CMD, in_ff.search_command, rom_ff,
                                          last_disc_ff, fam_ff, 1'b1);
               end
            end
            ACT_RESET: begin
               last_disc_in = '0;
               last_dev_in  = 1'b0;
               fam_in       = '0;
               searching_in = 1'b0;
               pos_in       = POS_W'(1);
               turn_pos_in  = '0;
            end
            ACT_BIT: begin
               if (searching_ff) begin
                  if (a_bit && b_bit) begin
                     // no device answered this bit
                     searching_in = 1'b0;
                     last_disc_in = '0;
                     last_dev_in  = 1'b0;
                     fam_in       = '0;
                     push.push0   = 1'b1;
                     push.res0    = make_rsp(KIND_NONE, '0, rom_ff, '0, '0, 1'b1);
                  end else begin
                     if (a_bit != b_bit) begin
                        dir = a_bit;
                     end else begin
                        // discrepancy: pick the branch from the previous pass
                        if (pos_ff < last_disc_ff) begin
                           dir = rom_ff[bit_idx];
                        end else begin
                           dir = (pos_ff == last_disc_ff);
                        end
                        if (!dir) begin
                           turn_pos_in = pos_ff;
                           if (pos_ff < POS_W'(FAMILY_LIMIT)) begin
                              fam_in = pos_ff[FAM_W-1:0];
                           end
                        end
                     end
                     rom_in[bit_idx] = dir;
                     pos_in          = pos_ff + POS_W'(1);
                     push.push0      = 1'b1;
                     if (pos_ff != POS_W'(ROM_BITS)) begin
                        push.res0 = make_rsp(KIND_DIR, CMD_W'(dir), rom_in, last_disc_ff,
                                             fam_in, 1'b1);
                     end else begin
                        // final bit: direction, then the search outcome
                        push.res0    = make_rsp(KIND_DIR, CMD_W'(dir), rom_in, last_disc_ff,
                                                fam_in, 1'b0);
                        push.push1   = 1'b1;
                        searching_in = 1'b0;
                        if (rom_in[7:0] == 8'd0) begin
                           last_disc_in = '0;
                           last_dev_in  = 1'b0;
                           fam_in       = '0;
                           push.res1    = make_rsp(KIND_NONE, '0, rom_in, '0, '0, 1'b1);
                        end else begin
                           last_disc_in = turn_pos_in;
                           last_dev_in  = (turn_pos_in == '0);
                           push.res1    = make_rsp(KIND_FOUND, '0, rom_in, turn_pos_in,
                                                   fam_in, 1'b1);
                        end
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      in_ff <= in_in;
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rom_ff       <= '0;
         last_disc_ff <= '0;
         last_dev_ff  <= 1'b0;
         fam_ff       <= '0;
         pos_ff       <= POS_W'(1);
         turn_pos_ff  <= '0;
         searching_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rom_ff       <= rom_in;
         last_disc_ff <= last_disc_in;
         last_dev_ff  <= last_dev_in;
         fam_ff       <= fam_in;
         pos_ff       <= pos_in;
         turn_pos_ff  <= turn_pos_in;
         searching_ff <= searching_in;
      end
   end

`ifndef SYNTHESIS
   // bit position stays within the search
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (pos_ff != '0) && (pos_ff <= POS_W'(ROM_BITS + 1)))
      else $error("bit position out of range");

   // a running search never sits past the last bit
   a_search_pos: assert property (@(posedge clock) disable iff (reset)
      searching_ff |-> (pos_ff <= POS_W'(ROM_BITS)))
      else $error("search running past last bit");

   // results only come from a held request
   a_push_src: assert property (@(posedge clock) disable iff (reset)
      push.push0 |-> in_valid_ff)
      else $error("result without request");
`endif

endmodule

/* hw/rtl/owrs_rsp_fifo.sv */
// ----------------------------------------------------------------------------
// owrs_rsp_fifo
// Small result queue taking up to two beats a cycle, giving one.
// ----------------------------------------------------------------------------
module owrs_rsp_fifo
   import owrs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     room,
   output logic     out_valid,
   input  logic     out_ready,
   output rsp_type  out_beat
);

   rsp_type              mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic [RSP_PTR_W-1:0] wr_ptr_p1;
   logic                 pop;

   // status
   assign room      = count_ff <= RSP_CNT_W'(RSP_DEPTH - 2);
   assign out_valid = count_ff != '0;
   assign out_beat  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign wr_ptr_p1 = wr_ptr_ff + RSP_PTR_W'(1);

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.push0) begin
         wr_ptr_in = wr_ptr_p1;
         count_in  = count_in + RSP_CNT_W'(1);
      end
      if (push.push1) begin
         wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(2);
         count_in  = count_in + RSP_CNT_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(1);
         count_in  = count_in - RSP_CNT_W'(1);
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push.push0) begin
         mem_ff[wr_ptr_ff] <= push.res0;
      end
      if (push.push1) begin
         mem_ff[wr_ptr_p1] <= push.res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   // never overfilled
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RSP_CNT_W'(RSP_DEPTH))
      else $error("result queue overflow");

   // second beat only together with the first
   a_push_pair: assert property (@(posedge clock) disable iff (reset)
      push.push1 |-> push.push0)
      else $error("second result without first");

   // pushes only when room was reported
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.push0 |-> room)
      else $error("result pushed without room");
`endif

endmodule

/* hw/rtl/onewire_rom_search.sv */
// ----------------------------------------------------------------------------
// onewire_rom_search
// 1-Wire search ROM engine, one bus event per request beat.
// ----------------------------------------------------------------------------
// Usage: req_chan carries one bus event per beat (start with presence and
// command byte, a read bit pair, or a search reset). rsp_chan returns what
// to drive next: the command byte, a direction bit, device found or no
// device, together with the current rom code and discrepancy state.
// A start or bit pair gives one result beat; the last bit of the code gives
// two (direction, then outcome). A reset beat, a bit pair while idle and
// unused action codes give none.
// Path: an accepted request beat is held in the request register; once the
// result queue has room its results are written into that queue and are
// shown on rsp_chan from there.
// Throughput: one request beat per cycle, set by the single-pass search step
// and the four-entry result queue, which must have two free entries.
// Reset: search state cleared, bit position back to one, queue empty.
// Stall: when rsp_chan.ready is low results collect in the queue; once fewer
// than two entries are free the request register keeps its beat and
// req_chan.ready drops until beats drain.
// ----------------------------------------------------------------------------
module onewire_rom_search
   import owrs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   owrs_req_if.sink     req_chan,
   owrs_rsp_if.source   rsp_chan
);

   req_type  req_beat;
   rsp_type  rsp_beat;
   push_type push;
   logic     room;
   logic     req_ready;
   logic     rsp_valid;

   // request beat from the channel
   assign req_beat.action         = req_chan.action;
   assign req_beat.presence       = req_chan.presence;
   assign req_beat.search_command = req_chan.search_command;
   assign req_beat.id_bit         = req_chan.id_bit;
   assign req_beat.complement_bit = req_chan.complement_bit;
   assign req_chan.ready          = req_ready;

   owrs_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_beat  (req_beat),
      .req_ready (req_ready),
      .room      (room),
      .push      (push)
   );

   owrs_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_valid),
      .out_ready (rsp_chan.ready),
      .out_beat  (rsp_beat)
   );

   // result beat to the channel
   assign rsp_chan.valid              = rsp_valid;
   assign rsp_chan.kind               = rsp_beat.kind;
   assign rsp_chan.bus_value          = rsp_beat.bus_value;
   assign rsp_chan.rom_code           = rsp_beat.rom_code;
   assign rsp_chan.discrepancy        = rsp_beat.discrepancy;
   assign rsp_chan.family_discrepancy = rsp_beat.family_discrepancy;
   assign rsp_chan.last               = rsp_beat.last;

endmodule
